@@ src/dcpt_pkg.sv @@
// Shared types and constants for the delta-correlating prefetcher.
// No dependencies.
package dcpt_pkg;

  localparam logic [31:0] PhysLimitReset = 32'hFFFF_FFFF;
  localparam logic [31:0] DeltaMax = 32'd2147483647;
  localparam int unsigned MaxOut = 3;

  typedef enum logic [0:0] {
    REG_PHYS_LIMIT = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] instr_addr;
    logic [31:0] access_addr;
  } req_t;

  typedef struct packed {
    logic [31:0] prefetch_addr;
    logic        issue;
    logic        last;
  } rsp_t;

endpackage

@@ src/delta_correlating_prefetcher_top.sv @@
// Requests are served one at a time: a new request is taken from the queue only once
// the previous one has finished its table read, candidate walk and results. Results
// then follow one per cycle while rsp_stall_i is low. The pace is set by the single
// table port and the serial candidate walk.
// Reset clears all entry valid bits at once and sets phys_limit to all ones.
// Depends on dcpt_pkg, dcpt_front, dcpt_back.
module delta_correlating_prefetcher_top
  import dcpt_pkg::*;
#(
  parameter int unsigned TableEntries = 64,
  parameter int unsigned HistoryDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  req_t        req_i,
  output logic        rsp_valid_o,
  input  logic        rsp_stall_i,
  output rsp_t        rsp_o
);

  logic [31:0] phys_limit_q;
  logic        q_valid, q_pop;
  req_t        q_data;

  assign pready = 1'b1;
  assign prdata = (paddr[1] == REG_PHYS_LIMIT) ? phys_limit_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) phys_limit_q <= PhysLimitReset;
    else if (psel && penable && pwrite && paddr[1] == REG_PHYS_LIMIT) phys_limit_q <= pwdata;
  end

  dcpt_front u_front (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .req_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  dcpt_back #(.TableEntries(TableEntries), .HistoryDepth(HistoryDepth)) u_back (
    .clk_i, .rst_ni, .phys_limit_i(phys_limit_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .rsp_valid_o, .rsp_stall_i, .rsp_o
  );

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_issue_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.issue |-> rsp_o.prefetch_addr == 32'd0)
    else $error("suppressed prefetch carries address");
  a_issue_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.issue |-> rsp_o.prefetch_addr < phys_limit_q)
    else $error("prefetch above limit");

endmodule

@@ src/dcpt_front.sv @@
// Front end: accept requests and hold them in a two-entry queue.
// Depends on dcpt_pkg.
module dcpt_front
  import dcpt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_stall_o,
  input  req_t req_i,
  output logic q_valid_o,
  input  logic q_pop_i,
  output req_t q_data_o
);

  req_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign req_stall_o = (cnt_q == 2'd2);
  assign push = req_valid_i && !req_stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

endmodule

@@ src/dcpt_back.sv @@
// Back end: table lookup, delta update, pair search and candidate issue.
// Depends on dcpt_pkg.
module dcpt_back
  import dcpt_pkg::*;
#(
  parameter int unsigned TableEntries = 64,
  parameter int unsigned HistoryDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] phys_limit_i,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  req_t        q_data_i,
  output logic        rsp_valid_o,
  input  logic        rsp_stall_i,
  output rsp_t        rsp_o
);

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned HistW = $clog2(HistoryDepth + 1);

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] prev_addr;
    logic [31:0] prev_pf;
    logic [HistoryDepth-1:0][30:0] hist;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_EMIT
  } state_e;

  entry_t              mem_q [TableEntries];
  logic [TableEntries-1:0] valid_q;
  entry_t              rd_q, ent_q;
  state_e              state_q;
  req_t                req_q;
  logic [IdxW-1:0]     idx;
  logic [31:0]         look_pc;
  logic [HistW-1:0]    k_q;
  logic [31:0]         sum_q;
  logic [31:0]         cand_q [MaxOut];
  logic [1:0]          cnt_q, emit_q;
  logic                hit;

  logic                mem_we;
  entry_t              mem_wd;
  logic [31:0]         d;
  entry_t              upd;
  logic                found;
  logic [HistW-1:0]    match;
  logic [31:0]         nsum;
  logic                ok;

  assign look_pc = (state_q == ST_IDLE) ? q_data_i.instr_addr : req_q.instr_addr;

  if (TableEntries > 1) begin : g_idx
    assign idx = look_pc[IdxW-1:0];
  end else begin : g_idx1
    assign idx = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[idx];
    if (mem_we) mem_q[idx] <= mem_wd;
  end

  always_comb begin
    hit = valid_q[idx] && (rd_q.tag == req_q.instr_addr);
    d = req_q.access_addr - rd_q.prev_addr;
    upd = rd_q;
    for (int i = HistoryDepth - 1; i > 0; i--) upd.hist[i] = rd_q.hist[i-1];
    upd.hist[0] = (d > DeltaMax) ? 31'd0 : d[30:0];
    upd.prev_addr = req_q.access_addr;
    found = 1'b0;
    match = '0;
    for (int n = HistoryDepth - 2; n >= 2; n--) begin
      if (upd.hist[n] == upd.hist[0] && upd.hist[n+1] == upd.hist[1]) begin
        found = 1'b1;
        match = HistW'(n);
      end
    end
    nsum = sum_q + {1'b0, ent_q.hist[k_q - 1'b1]};
    ok = cand_q[emit_q] < phys_limit_i;
  end

  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;
  assign rsp_valid_o = (state_q == ST_EMIT);
  assign rsp_o.prefetch_addr = ok ? cand_q[emit_q] : 32'd0;
  assign rsp_o.issue = ok;
  assign rsp_o.last = (emit_q == cnt_q - 2'd1);

  always_comb begin
    mem_we = 1'b0;
    mem_wd = ent_q;
    if (state_q == ST_READ) begin
      if (!hit) begin
        mem_we = 1'b1;
        mem_wd.tag = req_q.instr_addr;
        mem_wd.prev_addr = req_q.access_addr;
        mem_wd.prev_pf = '0;
        mem_wd.hist = '0;
      end else if (d != 32'd0) begin
        mem_we = 1'b1;
        mem_wd = upd;
      end
    end else if (state_q == ST_EMIT && !rsp_stall_i && ok) begin
      mem_we = 1'b1;
      mem_wd.prev_pf = cand_q[emit_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      k_q <= '0;
      cnt_q <= '0;
      emit_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            req_q <= q_data_i;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_IDLE;
          if (!hit) begin
            valid_q[idx] <= 1'b1;
          end else if (d != 32'd0) begin
            ent_q <= upd;
            sum_q <= req_q.access_addr;
            k_q <= match;
            cnt_q <= '0;
            emit_q <= '0;
            if (upd.hist[0] != '0 && upd.hist[1] != '0 && found) state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (k_q == '0 || ent_q.hist[k_q - 1'b1] == '0) begin
            state_q <= (cnt_q == '0) ? ST_IDLE : ST_EMIT;
          end else begin
            sum_q <= nsum;
            k_q <= k_q - 1'b1;
            if (nsum == ent_q.prev_pf) cnt_q <= '0;
            else if (cnt_q != 2'(MaxOut)) begin
              cand_q[cnt_q] <= nsum;
              cnt_q <= cnt_q + 2'd1;
            end
          end
        end
        ST_EMIT: begin
          if (!rsp_stall_i) begin
            if (ok) ent_q.prev_pf <= cand_q[emit_q];
            if (emit_q == cnt_q - 2'd1) state_q <= ST_IDLE;
            else emit_q <= emit_q + 2'd1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
